// File: hdl/bpba_pkg.sv
// Shared package of the banked page bitmap allocator.
// Holds command codes, register indexes, reset values and the leading-zero count.
// Depends on nothing.
package bpba_pkg;

  localparam int NUM_BANKS_DEF  = 2;
  localparam int BANK_WORDS_DEF = 1024;

  typedef logic [31:0] word_t;

  localparam logic [2:0] CMD_SET       = 3'd0;
  localparam logic [2:0] CMD_CLEAR     = 3'd1;
  localparam logic [2:0] CMD_TEST      = 3'd2;
  localparam logic [2:0] CMD_RUN_CLEAR = 3'd3;
  localparam logic [2:0] CMD_RUN_SET   = 3'd4;
  localparam logic [2:0] CMD_GRAB      = 3'd5;

  localparam logic [2:0] REG_BANKS_USED  = 3'd0;
  localparam logic [2:0] REG_BANK0_FIRST = 3'd1;
  localparam logic [2:0] REG_BANK0_LAST  = 3'd2;
  localparam logic [2:0] REG_BANK1_FIRST = 3'd3;
  localparam logic [2:0] REG_BANK1_LAST  = 3'd4;

  localparam logic [1:0] RST_BANKS_USED = 2'd1;
  localparam word_t RST_BANK0_FIRST = 32'd0;
  localparam word_t RST_BANK0_LAST  = 32'd32767;
  localparam word_t RST_BANK1_FIRST = 32'd32768;
  localparam word_t RST_BANK1_LAST  = 32'd65535;

  localparam word_t TOP_BIT = 32'h8000_0000;

  // Leading zeros of a nonzero word, found in five halving steps.
  function automatic logic [4:0] lead_zeros(input word_t x);
    word_t v;
    logic [4:0] n;
    v = x;
    n = '0;
    if (v[31:16] == 16'd0) begin n = n + 5'd16; v = v << 16; end
    if (v[31:24] == 8'd0) begin n = n + 5'd8; v = v << 8; end
    if (v[31:28] == 4'd0) begin n = n + 5'd4; v = v << 4; end
    if (v[31:30] == 2'd0) begin n = n + 5'd2; v = v << 2; end
    if (v[31] == 1'b0) begin n = n + 5'd1; end
    return n;
  endfunction

endpackage

// File: hdl/bpba_mem.sv
// Single-port bitmap word store with registered read data.
// Depends on bpba_pkg for the word type and default depth.
module bpba_mem
  import bpba_pkg::*;
#(
  parameter int DEPTH  = NUM_BANKS_DEF * BANK_WORDS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  word_t             wdata,
  output word_t             rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/banked_page_bitmap_allocator_top.sv
// Banked page bitmap allocator: top level with the command sequencer and APB registers.
// Depends on bpba_pkg and bpba_mem.
// Set, clear and test step through the lookup, read and data states from start to done;
// counts and grabs then scan the bitmap word by word through the single memory port,
// with a request state and a data state for each word.
// Reset is synchronous; afterwards a clearing pass writes zero to every word, one a cycle,
// while busy is high. Results cannot be stalled.
module banked_page_bitmap_allocator_top
  import bpba_pkg::*;
#(
  parameter int NUM_BANKS  = NUM_BANKS_DEF,
  parameter int BANK_WORDS = BANK_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [31:0] page,
  // result side
  output logic        done,
  output logic        in_bank,
  output logic        bit_value,
  output logic [15:0] run_length,
  output logic [31:0] next_page,
  output logic        none_found,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH  = NUM_BANKS * BANK_WORDS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ITER_W = $clog2(NUM_BANKS + 2);
  // Bits of storage owned by one bank.
  localparam logic [32:0] CAP = 33'(BANK_WORDS * 32);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LOOK = 4'd2;
  localparam logic [3:0] S_BRD  = 4'd3;
  localparam logic [3:0] S_BDAT = 4'd4;
  localparam logic [3:0] S_GSEL = 4'd5;
  localparam logic [3:0] S_SREQ = 4'd6;
  localparam logic [3:0] S_SDAT = 4'd7;
  localparam logic [3:0] S_SFIN = 4'd8;
  localparam logic [3:0] S_POST = 4'd9;

  // Configuration registers.
  logic [1:0] banks_used;
  word_t      bank_first [2];
  word_t      bank_last  [2];

  logic [3:0]        state;
  logic [ADDR_W-1:0] clr_cnt;

  // Latched item and the page lookup.
  logic [2:0] cmd;
  word_t      pg;
  logic       hit;
  logic       bank;
  word_t      poff;
  logic       pin_store;

  // Run scanner registers, shared by counts and grabs.
  logic        scan_bank;
  word_t       soff;
  logic [32:0] sn;
  logic [32:0] slim;
  logic [32:0] srun;
  logic        want_set;

  // Grab search registers.
  logic [32:0]       cand;
  logic [ITER_W-1:0] iter;

  // Memory port.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  word_t             mem_wdata;
  word_t             mem_rdata;

  bpba_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  // Banks in use: values of banks_used above NUM_BANKS act as NUM_BANKS.
  logic [1:0] active;
  logic [1:0] bvalid;
  assign active = (banks_used > 2'(NUM_BANKS)) ? 2'(NUM_BANKS) : banks_used;

  always_comb begin
    bvalid = '0;
    for (int k = 0; k < NUM_BANKS; k++) begin
      bvalid[k] = (2'(k) < active) && (bank_first[k] <= bank_last[k]);
    end
  end

  // Page lookup: the lowest-numbered valid bank that holds the page wins.
  logic look_hit;
  logic look_bank;
  always_comb begin
    look_hit  = 1'b0;
    look_bank = 1'b0;
    for (int k = NUM_BANKS - 1; k >= 0; k--) begin
      if (bvalid[k] && pg >= bank_first[k] && pg <= bank_last[k]) begin
        look_hit  = 1'b1;
        look_bank = 1'(k);
      end
    end
  end

  // Grab bank choice: a valid bank whose last page is not below the candidate.
  // When the candidate lies below its first page it snaps up to it.
  logic g_hit;
  logic g_bank;
  always_comb begin
    g_hit  = 1'b0;
    g_bank = 1'b0;
    for (int k = NUM_BANKS - 1; k >= 0; k--) begin
      if (bvalid[k] && cand <= {1'b0, bank_last[k]}) begin
        g_hit  = 1'b1;
        g_bank = 1'(k);
      end
    end
  end

  logic [32:0] g_cand;
  assign g_cand = (cand < {1'b0, bank_first[g_bank]}) ? {1'b0, bank_first[g_bank]} : cand;

  // Word address of a bank-relative bit offset.
  function automatic logic [ADDR_W-1:0] word_addr(input logic b, input word_t off);
    return (b ? ADDR_W'(BANK_WORDS) : ADDR_W'(0)) + ADDR_W'(off[31:5]);
  endfunction

  // Current word of the scan, inverted for set runs and aligned to the offset.
  word_t scan_x;
  assign scan_x = (want_set ? ~mem_rdata : mem_rdata) << soff[4:0];

  word_t pmask;
  assign pmask = TOP_BIT >> poff[4:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = word_addr(bank, poff);
    mem_wdata = '0;
    unique case (state)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      S_BDAT: begin
        mem_we    = hit && pin_store && (cmd == CMD_SET || cmd == CMD_CLEAR);
        mem_wdata = (cmd == CMD_SET) ? (mem_rdata | pmask) : (mem_rdata & ~pmask);
      end
      S_SREQ: begin
        mem_addr = word_addr(scan_bank, soff);
      end
      default: begin
      end
    endcase
  end

  // Configuration writes and reads.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      banks_used    <= RST_BANKS_USED;
      bank_first[0] <= RST_BANK0_FIRST;
      bank_last[0]  <= RST_BANK0_LAST;
      bank_first[1] <= RST_BANK1_FIRST;
      bank_last[1]  <= RST_BANK1_LAST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_BANKS_USED:  banks_used    <= pwdata[1:0];
        REG_BANK0_FIRST: bank_first[0] <= pwdata;
        REG_BANK0_LAST:  bank_last[0]  <= pwdata;
        REG_BANK1_FIRST: bank_first[1] <= pwdata;
        REG_BANK1_LAST:  bank_last[1]  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BANKS_USED:  prdata = {30'd0, banks_used};
      REG_BANK0_FIRST: prdata = bank_first[0];
      REG_BANK0_LAST:  prdata = bank_last[0];
      REG_BANK1_FIRST: prdata = bank_first[1];
      REG_BANK1_LAST:  prdata = bank_last[1];
      default:         prdata = '0;
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_BRD;
        S_BRD:  state <= S_BDAT;
        S_BDAT: begin
          if ((cmd == CMD_RUN_CLEAR || cmd == CMD_RUN_SET) && hit) begin
            state <= S_SREQ;
          end else if (cmd == CMD_GRAB) begin
            state <= S_GSEL;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_GSEL: begin
          if (iter > ITER_W'(NUM_BANKS) || !g_hit) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_SREQ;
          end
        end
        S_SREQ: begin
          if (sn >= slim || {1'b0, soff} >= CAP) begin
            state <= S_SFIN;
          end else begin
            state <= S_SDAT;
          end
        end
        S_SDAT: begin
          if (scan_x != 32'd0) begin
            state <= S_SFIN;
          end else begin
            state <= S_SREQ;
          end
        end
        S_SFIN: state <= S_POST;
        S_POST: begin
          if (cmd == CMD_GRAB && (cand + srun) > {1'b0, bank_last[scan_bank]}) begin
            state <= S_GSEL;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd        <= command;
        pg         <= page;
        run_length <= '0;
        next_page  <= '0;
        none_found <= 1'b0;
        iter       <= '0;
      end
      S_LOOK: begin
        hit       <= look_hit;
        bank      <= look_bank;
        poff      <= pg - bank_first[look_bank];
        pin_store <= {1'b0, pg - bank_first[look_bank]} < CAP;
      end
      S_BDAT: begin
        in_bank <= hit;
        // The bit after the command; pages without storage read as set.
        if (!hit || !pin_store) begin
          bit_value <= 1'b1;
        end else if (cmd == CMD_SET) begin
          bit_value <= 1'b1;
        end else if (cmd == CMD_CLEAR) begin
          bit_value <= 1'b0;
        end else begin
          bit_value <= mem_rdata[5'd31 - poff[4:0]];
        end
        scan_bank <= bank;
        soff      <= poff;
        sn        <= '0;
        slim      <= {1'b0, bank_last[bank]} - {1'b0, pg} + 33'd1;
        want_set  <= (cmd == CMD_RUN_SET);
        cand      <= {1'b0, pg} + 33'd1;
      end
      S_GSEL: begin
        if (iter > ITER_W'(NUM_BANKS) || !g_hit) begin
          none_found <= 1'b1;
          next_page  <= '0;
        end
        scan_bank <= g_bank;
        cand      <= g_cand;
        soff      <= g_cand[31:0] - bank_first[g_bank];
        sn        <= '0;
        slim      <= {1'b0, bank_last[g_bank]} - g_cand + 33'd1;
        want_set  <= 1'b0;
      end
      S_SREQ: begin
        // Past the bank's storage every bit reads as set.
        if (sn < slim && {1'b0, soff} >= CAP && want_set) begin
          sn <= slim;
        end
      end
      S_SDAT: begin
        if (scan_x != 32'd0) begin
          sn <= sn + 33'(lead_zeros(scan_x));
        end else begin
          sn   <= sn + 33'(6'd32 - {1'b0, soff[4:0]});
          soff <= soff + 32'(6'd32 - {1'b0, soff[4:0]});
        end
      end
      S_SFIN: begin
        srun <= (sn > slim) ? slim : sn;
      end
      S_POST: begin
        if (cmd == CMD_GRAB) begin
          cand <= cand + srun;
          iter <= iter + 1'b1;
          if ((cand + srun) <= {1'b0, bank_last[scan_bank]}) begin
            next_page <= 32'(cand + srun);
          end
        end else begin
          run_length <= (srun > 33'd65535) ? 16'hFFFF : srun[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // A result is only ever given as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // A failed grab reports page zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && none_found) |-> (next_page == 32'd0))
    else $error("no page found but next_page nonzero");

  // A nonzero run only comes from a page inside a bank.
  a_run_bank: assert property (@(posedge clk) disable iff (rst)
    (done && run_length != 16'd0) |-> in_bank)
    else $error("run length for a page outside every bank");

endmodule
